>>> hw/rtl/dib_pkg.sv
// ----------------------------------------------------------------------------
// dib_pkg
// Shared codes, register indexes and types of the bitmap pixel decoder.
// ----------------------------------------------------------------------------
package dib_pkg;

	localparam int CFG_W = 14;

	typedef logic [1:0] reg_idx_t;

	localparam reg_idx_t REG_DEPTH_MODE = 2'd0;
	localparam reg_idx_t REG_WIDTH      = 2'd1;
	localparam reg_idx_t REG_HEIGHT     = 2'd2;
	localparam reg_idx_t REG_TOP_DOWN   = 2'd3;

	localparam logic ACT_PALETTE = 1'b0;
	localparam logic ACT_PIXEL   = 1'b1;

	localparam logic [2:0] MODE_1BPP  = 3'd0;
	localparam logic [2:0] MODE_4BPP  = 3'd1;
	localparam logic [2:0] MODE_8BPP  = 3'd2;
	localparam logic [2:0] MODE_24BPP = 3'd3;
	localparam logic [2:0] MODE_32BPP = 3'd4;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [23:0] rgb;
		logic [12:0] column;
		logic [12:0] row;
		logic        last_run;
		logic        last_image;
	} pixel_t;

endpackage

>>> hw/rtl/dib_ram.sv
// ----------------------------------------------------------------------------
// dib_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dib_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/dib_pixel_decoder.sv
// ----------------------------------------------------------------------------
// dib_pixel_decoder
// Streaming decoder for uncompressed bitmap pixel data with palette lookup.
// ----------------------------------------------------------------------------
// A byte's first pixel passes the expander, the lookup stage and the result queue.
// Throughput: one byte per cycle at 8, 24 and 32 bpp while the queue has room, and for
// palette writes; a 4 or 1 bpp byte is held for its palette reads, one per cycle.
// Output goes through a 4-entry queue; the input keeps flowing while it drains.
// Reset clears position, phase and queue state and loads register defaults;
// palette contents are undefined until written.
module dib_pixel_decoder #(
	parameter int MAX_DIMENSION   = 8192,
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  dib_pkg::reg_idx_t         cfg_index,
	input  logic [dib_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      action,
	input  logic [7:0]                data_byte,
	input  logic [7:0]                palette_index,
	input  logic [7:0]                palette_blue,
	input  logic [7:0]                palette_green,
	input  logic [7:0]                palette_red,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [23:0]               pixel_rgb,
	output logic [12:0]               pixel_column,
	output logic [12:0]               pixel_row,
	output logic                      last_of_run,
	output logic                      last_of_image
);

	import dib_pkg::*;

	localparam int DW  = ($clog2(MAX_DIMENSION + 1) > 14) ? $clog2(MAX_DIMENSION + 1) : 14;
	localparam int CW  = DW + 2;
	localparam int PW  = DW + 6;
	localparam int RBW = $clog2(MAX_DIMENSION * 4 + 1);
	localparam int AW  = $clog2(PALETTE_ENTRIES);
	localparam logic [DW-1:0] MAX_D = DW'(MAX_DIMENSION);

	// configuration
	logic [2:0]  mode_q;
	logic [13:0] width_q;
	logic [13:0] height_q;
	logic        top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_8BPP;
			width_q  <= 14'd1;
			height_q <= 14'd1;
			top_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEPTH_MODE: mode_q   <= cfg_data[2:0];
				REG_WIDTH:      width_q  <= cfg_data[13:0];
				REG_HEIGHT:     height_q <= cfg_data[13:0];
				REG_TOP_DOWN:   top_q    <= cfg_data[0];
			endcase
		end
	end

	logic [2:0]    mode;
	logic [DW-1:0] w, h;
	logic [PW-1:0] wb, data_bytes, row_bytes;
	logic          direct_mode;

	always_comb begin
		mode = (mode_q > MODE_32BPP) ? MODE_8BPP : mode_q;
		if (width_q == 14'd0) w = DW'(1);
		else if (DW'(width_q) > MAX_D) w = MAX_D;
		else w = DW'(width_q);
		if (height_q == 14'd0) h = DW'(1);
		else if (DW'(height_q) > MAX_D) h = MAX_D;
		else h = DW'(height_q);
		unique case (mode)
			MODE_1BPP:  wb = PW'(w);
			MODE_4BPP:  wb = PW'(w) << 2;
			MODE_8BPP:  wb = PW'(w) << 3;
			MODE_24BPP: wb = (PW'(w) << 4) + (PW'(w) << 3);
			default:    wb = PW'(w) << 5;
		endcase
		data_bytes  = (wb + PW'(7)) >> 3;
		row_bytes   = ((wb + PW'(31)) >> 5) << 2;
		direct_mode = (mode == MODE_24BPP) || (mode == MODE_32BPP);
	end

	// expander: holds one request and steps through its pixels
	logic          exp_v_q;
	logic [2:0]    exp_k_q;
	logic          exp_action_q;
	logic [7:0]    exp_byte_q;
	logic [7:0]    exp_pidx_q;
	logic [23:0]   exp_color_q;

	logic [CW-1:0]  column_q;
	logic [RBW-1:0] rbc_q;
	logic [DW-1:0]  src_row_q;
	logic [15:0]    partial_q;
	logic [1:0]     phase_q;

	logic               s1_v_q;
	logic [FIFO_CW-1:0] cnt_q;

	logic          in_data, direct_emit, is_last, emit, col_in_w, col_last;
	logic          credit_ok, step_go, issue, row_end, rd_oob, wr_oob;
	logic [3:0]    nemit;
	logic [7:0]    pal_idx;
	logic [DW-1:0] srow, orow;
	logic [DW:0]   src_row_inc;

	always_comb begin
		in_data     = PW'(rbc_q) < data_bytes;
		direct_emit = in_data && direct_mode &&
		              (phase_q == 2'd2 || (phase_q == 2'd3 && mode == MODE_24BPP));
		nemit = 4'd0;
		if (exp_action_q == ACT_PIXEL && in_data) begin
			unique case (mode)
				MODE_1BPP: nemit = 4'd8;
				MODE_4BPP: nemit = 4'd2;
				MODE_8BPP: nemit = 4'd1;
				default:   nemit = direct_emit ? 4'd1 : 4'd0;
			endcase
		end
		is_last  = (nemit == 4'd0) || ({1'b0, exp_k_q} == nemit - 4'd1);
		emit     = (exp_action_q == ACT_PIXEL) && (nemit != 4'd0);
		col_in_w = column_q < CW'(w);
		col_last = column_q == CW'(w) - CW'(1);
		credit_ok = (cnt_q + FIFO_CW'(s1_v_q)) < FIFO_CW'(FIFO_DEPTH);
		step_go  = exp_v_q && (exp_action_q == ACT_PALETTE || credit_ok);
		issue    = step_go && emit && col_in_w;
		row_end  = (PW'(rbc_q) + PW'(1)) >= row_bytes;
		srow     = (src_row_q < h) ? src_row_q : h - DW'(1);
		orow     = top_q ? srow : h - DW'(1) - srow;
		src_row_inc = {1'b0, src_row_q} + (DW+1)'(1);
		unique case (mode)
			MODE_1BPP: pal_idx = {7'd0, exp_byte_q[3'd7 - exp_k_q]};
			MODE_4BPP: pal_idx = exp_k_q[0] ? {4'd0, exp_byte_q[3:0]} : {4'd0, exp_byte_q[7:4]};
			default:   pal_idx = exp_byte_q;
		endcase
		rd_oob = {1'b0, pal_idx} >= 9'(PALETTE_ENTRIES);
		wr_oob = {1'b0, exp_pidx_q} >= 9'(PALETTE_ENTRIES);
	end

	assign in_stall = exp_v_q && !(step_go && is_last);

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			exp_action_q <= action;
			exp_byte_q   <= data_byte;
			exp_pidx_q   <= palette_index;
			exp_color_q  <= {palette_red, palette_green, palette_blue};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_v_q   <= 1'b0;
			exp_k_q   <= '0;
			column_q  <= '0;
			rbc_q     <= '0;
			src_row_q <= '0;
			partial_q <= '0;
			phase_q   <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				exp_v_q <= 1'b1;
				exp_k_q <= '0;
			end else if (step_go) begin
				if (is_last) exp_v_q <= 1'b0;
				else exp_k_q <= exp_k_q + 3'd1;
			end
			if (step_go && exp_action_q == ACT_PIXEL) begin
				if (is_last && row_end) begin
					rbc_q     <= '0;
					column_q  <= '0;
					partial_q <= '0;
					phase_q   <= '0;
					src_row_q <= (src_row_inc >= {1'b0, h}) ? '0 : src_row_inc[DW-1:0];
				end else begin
					if (emit) column_q <= column_q + CW'(1);
					if (is_last) begin
						rbc_q <= rbc_q + RBW'(1);
						if (in_data && direct_mode) begin
							if (phase_q == 2'd0) begin
								partial_q <= {8'd0, exp_byte_q};
								phase_q   <= 2'd1;
							end else if (phase_q == 2'd1) begin
								partial_q[15:8] <= exp_byte_q;
								phase_q         <= 2'd2;
							end else if (phase_q == 2'd2 || mode == MODE_24BPP) begin
								partial_q <= '0;
								phase_q   <= (mode == MODE_32BPP) ? 2'd3 : 2'd0;
							end else begin
								phase_q <= 2'd0;
							end
						end
					end
				end
			end
		end
	end

	// palette store
	logic [23:0] pal_rdata;

	dib_ram #(
		.WIDTH(24),
		.DEPTH(PALETTE_ENTRIES)
	) u_palette (
		.clk  (clk),
		.we   (step_go && exp_action_q == ACT_PALETTE && !wr_oob),
		.waddr(exp_pidx_q[AW-1:0]),
		.wdata(exp_color_q),
		.re   (issue),
		.raddr(pal_idx[AW-1:0]),
		.rdata(pal_rdata)
	);

	// lookup stage
	logic        s1_direct, s1_oob, s1_lrun, s1_limg;
	logic [23:0] s1_rgb;
	logic [12:0] s1_col, s1_row;

	always_ff @(posedge clk) begin
		if (issue) begin
			s1_direct <= direct_mode;
			s1_oob    <= rd_oob;
			s1_rgb    <= {exp_byte_q, partial_q};
			s1_col    <= column_q[12:0];
			s1_row    <= orow[12:0];
			s1_lrun   <= is_last || col_last;
			s1_limg   <= col_last && (srow == h - DW'(1));
		end
	end

	// result queue
	pixel_t             fifo_q [FIFO_DEPTH];
	logic [FIFO_PW-1:0] wr_ptr_q, rd_ptr_q;
	pixel_t             push_pix;
	logic               pop;

	always_comb begin
		push_pix.rgb        = s1_direct ? s1_rgb : (s1_oob ? 24'd0 : pal_rdata);
		push_pix.column     = s1_col;
		push_pix.row        = s1_row;
		push_pix.last_run   = s1_lrun;
		push_pix.last_image = s1_limg;
	end

	assign out_valid     = cnt_q != '0;
	assign pop           = out_valid && !out_stall;
	assign pixel_rgb     = fifo_q[rd_ptr_q].rgb;
	assign pixel_column  = fifo_q[rd_ptr_q].column;
	assign pixel_row     = fifo_q[rd_ptr_q].row;
	assign last_of_run   = fifo_q[rd_ptr_q].last_run;
	assign last_of_image = fifo_q[rd_ptr_q].last_image;

	always_ff @(posedge clk) begin
		if (s1_v_q) fifo_q[wr_ptr_q] <= push_pix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q   <= 1'b0;
			cnt_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			s1_v_q <= issue;
			if (s1_v_q) wr_ptr_q <= wr_ptr_q + FIFO_PW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + FIFO_PW'(1);
			cnt_q <= cnt_q + FIFO_CW'(s1_v_q) - FIFO_CW'(pop);
		end
	end

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q + FIFO_CW'(s1_v_q)) <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue over-committed");

	a_sub_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(exp_v_q && exp_action_q == ACT_PIXEL && nemit != 4'd0) |-> ({1'b0, exp_k_q} < nemit))
		else $error("sub-step past pixel count");

	a_image_end_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_of_image) |-> last_of_run)
		else $error("image end without run end");

	a_accept_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(exp_v_q && in_valid && !in_stall) |-> (step_go && is_last))
		else $error("request overwritten mid-expansion");

endmodule
